FILE: rtl/core/mabs_pkg.sv
// Package for the multi-axis Bresenham step generator.
// Holds field widths, the axis count, opcodes and shared types; no dependencies.
`timescale 1ns / 1ps

package mabs_pkg;

  localparam int AXES       = 5;
  localparam int COUNT_BITS = 16;
  localparam int ACC_BITS   = COUNT_BITS + 1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ACC_BITS-1:0]   accum_t;
  typedef logic [AXES-1:0]       axis_mask_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

endpackage

FILE: rtl/core/mabs_in_if.sv
// Input channel of the step generator: valid/ready plus one load or tick word.
// Depends on mabs_pkg for the field types.
`timescale 1ns / 1ps

interface mabs_in_if;
  logic              valid;
  logic              ready;
  mabs_pkg::op_t     op;
  mabs_pkg::count_t  count_axis0;
  mabs_pkg::count_t  count_axis1;
  mabs_pkg::count_t  count_axis2;
  mabs_pkg::count_t  count_axis3;
  mabs_pkg::count_t  count_axis4;
  mabs_pkg::count_t  move_length;

  modport source (
    output valid, op, count_axis0, count_axis1, count_axis2, count_axis3,
           count_axis4, move_length,
    input  ready
  );
  modport sink (
    input  valid, op, count_axis0, count_axis1, count_axis2, count_axis3,
           count_axis4, move_length,
    output ready
  );
endinterface

FILE: rtl/core/mabs_out_if.sv
// Result channel of the step generator: valid/ready plus one pulse word.
// No package dependencies.
`timescale 1ns / 1ps

interface mabs_out_if;
  logic valid;
  logic ready;
  logic pulse_axis0;
  logic pulse_axis1;
  logic pulse_axis2;
  logic pulse_axis3;
  logic pulse_axis4;
  logic move_last;
  logic idle_tick;

  modport source (
    output valid, pulse_axis0, pulse_axis1, pulse_axis2, pulse_axis3,
           pulse_axis4, move_last, idle_tick,
    input  ready
  );
  modport sink (
    input  valid, pulse_axis0, pulse_axis1, pulse_axis2, pulse_axis3,
           pulse_axis4, move_last, idle_tick,
    output ready
  );
endinterface

FILE: rtl/core/multi_axis_bresenham_stepper.sv
// Top level of the five-axis Bresenham step generator.
// Depends on mabs_pkg, mabs_in_if and mabs_out_if.
//
//   channel  direction  word                                     results
//   in_ch    sink       op, count_axis0..4, move_length          load: none, tick: one
//   out_ch   source     pulse_axis0..4, move_last, idle_tick     one per tick
//
// The axis adds and compares are combinational and sit between the move
// state registers and the result register. A new word is taken every cycle
// while the result register is empty or being drained at the same edge.
// A stalled result holds only the input side; loads are held behind it too.
// Synchronous reset clears the move state and empties the result register.
`timescale 1ns / 1ps

module multi_axis_bresenham_stepper (
  input  logic      clk,
  input  logic      rst,
  mabs_in_if.sink   in_ch,
  mabs_out_if.source out_ch
);
  import mabs_pkg::*;

  count_t axis_counts [AXES];
  accum_t error_accum [AXES];
  count_t move_total;
  count_t ticks_left;

  count_t     in_counts [AXES];
  count_t     load_counts [AXES];
  accum_t     tick_accum [AXES];
  axis_mask_t tick_pulse;
  count_t     ticks_left_next;

  logic       out_valid;
  axis_mask_t out_pulse;
  logic       out_last;
  logic       out_idle;

  logic in_take;
  logic tick_take;
  logic load_take;
  logic move_active;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign tick_take   = in_take && (in_ch.op == OP_TICK);
  assign load_take   = in_take && (in_ch.op == OP_LOAD);
  assign move_active = (ticks_left != '0);

  assign in_counts[0] = in_ch.count_axis0;
  assign in_counts[1] = in_ch.count_axis1;
  assign in_counts[2] = in_ch.count_axis2;
  assign in_counts[3] = in_ch.count_axis3;
  assign in_counts[4] = in_ch.count_axis4;

  // Accumulators never pass twice the total, so the extra bit keeps the add exact.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      load_counts[a] = (in_counts[a] > in_ch.move_length) ? in_ch.move_length
                                                           : in_counts[a];
      tick_accum[a]  = error_accum[a] + {1'b0, axis_counts[a]};
      tick_pulse[a]  = (tick_accum[a] > {1'b0, move_total});
      if (tick_pulse[a]) begin
        tick_accum[a] = tick_accum[a] - {1'b0, move_total};
      end
    end
    ticks_left_next = ticks_left - count_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_total <= '0;
      ticks_left <= '0;
      for (int a = 0; a < AXES; a++) begin
        axis_counts[a] <= '0;
        error_accum[a] <= '0;
      end
    end else if (load_take) begin
      move_total <= in_ch.move_length;
      ticks_left <= in_ch.move_length;
      for (int a = 0; a < AXES; a++) begin
        axis_counts[a] <= load_counts[a];
        error_accum[a] <= {2'b00, in_ch.move_length[COUNT_BITS-1:1]};
      end
    end else if (tick_take && move_active) begin
      ticks_left <= ticks_left_next;
      for (int a = 0; a < AXES; a++) begin
        error_accum[a] <= tick_accum[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      out_pulse <= move_active ? tick_pulse : '0;
      out_last  <= move_active && (ticks_left_next == '0);
      out_idle  <= !move_active;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.pulse_axis0 = out_pulse[0];
  assign out_ch.pulse_axis1 = out_pulse[1];
  assign out_ch.pulse_axis2 = out_pulse[2];
  assign out_ch.pulse_axis3 = out_pulse[3];
  assign out_ch.pulse_axis4 = out_pulse[4];
  assign out_ch.move_last   = out_last;
  assign out_ch.idle_tick   = out_idle;

`ifndef SYNTHESIS
  logic accum_in_range;
  logic counts_in_range;

  always_comb begin
    accum_in_range  = 1'b1;
    counts_in_range = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      if (error_accum[a] > {1'b0, move_total}) accum_in_range = 1'b0;
      if (axis_counts[a] > move_total) counts_in_range = 1'b0;
    end
  end

  a_accum_bounded: assert property (@(posedge clk) disable iff (rst)
    accum_in_range) else $error("error accumulator above move total");

  a_counts_clamped: assert property (@(posedge clk) disable iff (rst)
    counts_in_range && (ticks_left <= move_total))
    else $error("axis count or remaining ticks above move total");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_idle) |-> (out_pulse == '0) && !out_last)
    else $error("idle result carries pulses or end of move");

  a_last_ends_move: assert property (@(posedge clk) disable iff (rst)
    (tick_take && move_active && (ticks_left == count_t'(1))) |=> !move_active)
    else $error("final tick left the move active");
`endif

endmodule
